### hdl/assert_macros.svh
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on i_clk, off while reset is low
`define VAR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on i_clk, reset included
`define VAR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/var_pkg.sv
// shared types and constants of the voice activity rate tracker
`timescale 1ns / 1ps
package var_pkg;

    localparam int ONSET_DEPTH_DEF = 32;
    localparam int SR_W            = 18;
    localparam int THR_W           = 16;
    localparam int WIN_W           = 20;
    localparam int LEN_W           = 16;
    localparam int RMS_W           = 16;
    localparam int CNT_W           = 48;
    localparam int Q_W             = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 20;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [Q_W-1:0]   Q_MAX   = '1;
    localparam logic [SR_W-1:0]  SR_RST  = 18'd48000;
    localparam logic [THR_W-1:0] THR_RST = 16'd1024;
    localparam logic [WIN_W-1:0] WIN_RST = 20'd240000;

    // input command codes
    localparam logic CMD_ANALYZE = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE     = 2'd0,
        CFG_VOICE_THRESHOLD = 2'd1,
        CFG_HISTORY_WINDOW  = 2'd2
    } t_cfg_idx;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic update;
        logic rd_last;
        logic pop;
        logic cap_first;
        logic cap_last;
        logic p_init;
        logic r_init;
        logic div_step;
        logic p_store;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_clear;
        logic evict;
        logic div_done;
    } t_sts;

endpackage

### hdl/var_ctrl.sv
// sequencing state machine of the voice activity rate tracker
`timescale 1ns / 1ps
module var_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  var_pkg::t_sts i_sts,
    output var_pkg::t_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_UPDATE = 12'b000000000010,
        S_EV_RD  = 12'b000000000100,
        S_EV_CHK = 12'b000000001000,
        S_P_INIT = 12'b000000010000,
        S_P_DIV  = 12'b000000100000,
        S_R_RDF  = 12'b000001000000,
        S_R_RDL  = 12'b000010000000,
        S_R_MUL  = 12'b000100000000,
        S_R_INIT = 12'b001000000000,
        S_R_DIV  = 12'b010000000000,
        S_FINISH = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.is_clear ? S_FINISH : S_EV_RD;
            end
            S_EV_RD: begin
                n_state = S_EV_CHK;
            end
            S_EV_CHK: begin
                if (i_sts.evict) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_EV_RD;
                end else begin
                    n_state = S_P_INIT;
                end
            end
            S_P_INIT: begin
                o_cmd.p_init = 1'b1;
                n_state      = S_P_DIV;
            end
            S_P_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.p_store = 1'b1;
                    n_state       = S_R_RDF;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_R_RDF: begin
                n_state = S_R_RDL;
            end
            S_R_RDL: begin
                o_cmd.cap_first = 1'b1;
                o_cmd.rd_last   = 1'b1;
                n_state         = S_R_MUL;
            end
            S_R_MUL: begin
                o_cmd.cap_last = 1'b1;
                n_state        = S_R_INIT;
            end
            S_R_INIT: begin
                o_cmd.r_init = 1'b1;
                n_state      = S_R_DIV;
            end
            S_R_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/var_datapath.sv
// counters, onset ring, shared divider and output registers
`timescale 1ns / 1ps
module var_datapath #(
    parameter int DEPTH = var_pkg::ONSET_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [var_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [var_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_command,
    input  logic [var_pkg::LEN_W-1:0]      i_frame_length,
    input  logic [var_pkg::RMS_W-1:0]      i_rms_level,
    input  var_pkg::t_cmd                  i_cmd,
    output var_pkg::t_sts                  o_sts,
    output logic                           o_voiced,
    output logic [var_pkg::Q_W-1:0]        o_pause_q16,
    output logic [var_pkg::Q_W-1:0]        o_rate_q8
);

    localparam int CNT_W = var_pkg::CNT_W;
    localparam int Q_W   = var_pkg::Q_W;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = AW + var_pkg::SR_W;
    localparam int NW    = PW + 8;
    localparam int SW    = $clog2(NW + 1);

    typedef logic [AW:0] t_sum;

    // configuration
    logic [var_pkg::SR_W-1:0]  r_sr;
    logic [var_pkg::THR_W-1:0] r_thr;
    logic [var_pkg::WIN_W-1:0] r_win;

    // captured word
    logic                      r_clr;
    logic [var_pkg::LEN_W-1:0] r_len;
    logic [var_pkg::RMS_W-1:0] r_rms;

    // statistics and ring control
    logic [CNT_W-1:0] r_total, r_vcnt;
    logic             r_prev, r_voice;
    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_count;

    // ring memory
    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0] r_rdata;

    // rate operands
    logic [CNT_W-1:0] r_first, r_last;
    logic [PW-1:0]    r_prod;

    // divider
    logic [CNT_W-1:0] r_rem, r_dvs;
    logic [NW-1:0]    r_num, r_q;
    logic [SW-1:0]    r_step;
    logic [Q_W-1:0]   r_pause;

    // output word
    logic             r_o_voice;
    logic [Q_W-1:0]   r_o_pause, r_o_rate;

    logic             voiced, onset, full, evict_cmp, rate_ok;
    logic [CNT_W:0]   sum_t, sum_v, ev_sum, dv_t, dv_d;
    logic [CNT_W-1:0] n_total, n_vcnt;
    t_sum             tail_sum;
    logic [AW-1:0]    tail_idx, last_idx, rd_addr, head_inc, cm1;
    logic             dv_ge;
    logic [Q_W-1:0]   rate_val;

    // frame update values
    assign voiced  = r_rms > r_thr;
    assign sum_t   = {1'b0, r_total} + (CNT_W + 1)'(r_len);
    assign sum_v   = {1'b0, r_vcnt} + (CNT_W + 1)'(r_len);
    assign n_total = sum_t[CNT_W] ? var_pkg::CNT_MAX : sum_t[CNT_W-1:0];
    assign n_vcnt  = voiced ? (sum_v[CNT_W] ? var_pkg::CNT_MAX : sum_v[CNT_W-1:0]) : r_vcnt;
    assign onset   = voiced && !r_prev;
    assign full    = (r_count == CW'(DEPTH));

    // ring indexes
    assign tail_sum = t_sum'(r_head) + t_sum'(r_count);
    assign tail_idx = (tail_sum >= t_sum'(DEPTH)) ? AW'(tail_sum - t_sum'(DEPTH))
                                                 : AW'(tail_sum);
    assign last_idx = (tail_idx == '0) ? AW'(DEPTH - 1) : tail_idx - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign rd_addr  = i_cmd.rd_last ? last_idx : r_head;
    assign cm1      = AW'(r_count - CW'(1));

    // eviction test on the oldest onset
    assign ev_sum    = {1'b0, r_rdata} + (CNT_W + 1)'(r_win);
    assign evict_cmp = ev_sum < {1'b0, r_total};

    // one restoring divider step
    assign dv_t  = {r_rem, r_num[NW-1]};
    assign dv_ge = dv_t >= {1'b0, r_dvs};
    assign dv_d  = dv_t - {1'b0, r_dvs};

    // speech rate from the quotient
    assign rate_ok  = (r_count >= CW'(2)) && (r_last > r_first);
    assign rate_val = !rate_ok ? '0 : ((|r_q[NW-1:Q_W]) ? var_pkg::Q_MAX : r_q[Q_W-1:0]);

    assign o_sts.is_clear = (r_clr == var_pkg::CMD_CLEAR);
    assign o_sts.evict    = (r_count != '0) && evict_cmp;
    assign o_sts.div_done = (r_step == '0);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr  <= var_pkg::SR_RST;
            r_thr <= var_pkg::THR_RST;
            r_win <= var_pkg::WIN_RST;
        end else if (i_cfg_we) begin
            unique case (var_pkg::t_cfg_idx'(i_cfg_idx))
                var_pkg::CFG_SAMPLE_RATE:     r_sr  <= i_cfg_data[var_pkg::SR_W-1:0];
                var_pkg::CFG_VOICE_THRESHOLD: r_thr <= i_cfg_data[var_pkg::THR_W-1:0];
                var_pkg::CFG_HISTORY_WINDOW:  r_win <= i_cfg_data[var_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // statistics and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_vcnt  <= '0;
            r_prev  <= 1'b0;
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.update) begin
            if (r_clr == var_pkg::CMD_CLEAR) begin
                r_total <= '0;
                r_vcnt  <= '0;
                r_prev  <= 1'b0;
                r_head  <= '0;
                r_count <= '0;
            end else begin
                r_total <= n_total;
                r_vcnt  <= n_vcnt;
                r_prev  <= voiced;
                if (onset) begin
                    if (full) begin
                        r_head <= head_inc;
                    end else begin
                        r_count <= r_count + CW'(1);
                    end
                end
            end
        end else if (i_cmd.pop) begin
            r_head  <= head_inc;
            r_count <= r_count - CW'(1);
        end
    end

    // onset ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && (r_clr != var_pkg::CMD_CLEAR) && onset) begin
            r_mem[full ? r_head : tail_idx] <= n_total;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // captured word, rate operands and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clr <= i_command;
            r_len <= i_frame_length;
            r_rms <= i_rms_level;
        end
        if (i_cmd.update) begin
            r_voice <= (r_clr != var_pkg::CMD_CLEAR) && voiced;
        end
        if (i_cmd.cap_first) begin
            r_first <= r_rdata;
        end
        if (i_cmd.cap_last) begin
            r_last <= r_rdata;
            r_prod <= PW'(cm1) * PW'(r_sr);
        end
        if (i_cmd.p_init) begin
            r_rem  <= r_total - r_vcnt;
            r_dvs  <= r_total;
            r_num  <= '0;
            r_q    <= '0;
            r_step <= SW'(Q_W);
        end else if (i_cmd.r_init) begin
            r_rem  <= '0;
            r_dvs  <= r_last - r_first;
            r_num  <= {r_prod, 8'd0};
            r_q    <= '0;
            r_step <= SW'(NW);
        end else if (i_cmd.div_step) begin
            r_rem  <= dv_ge ? dv_d[CNT_W-1:0] : dv_t[CNT_W-1:0];
            r_num  <= {r_num[NW-2:0], 1'b0};
            r_q    <= {r_q[NW-2:0], dv_ge};
            r_step <= r_step - SW'(1);
        end
        if (i_cmd.p_store) begin
            if (r_total == '0) begin
                r_pause <= '0;
            end else if (r_vcnt == '0) begin
                r_pause <= var_pkg::Q_MAX;
            end else begin
                r_pause <= r_q[Q_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            if (r_clr == var_pkg::CMD_CLEAR) begin
                r_o_voice <= 1'b0;
                r_o_pause <= '0;
                r_o_rate  <= '0;
            end else begin
                r_o_voice <= r_voice;
                r_o_pause <= r_pause;
                r_o_rate  <= rate_val;
            end
        end
    end

    assign o_voiced    = r_o_voice;
    assign o_pause_q16 = r_o_pause;
    assign o_rate_q8   = r_o_rate;

endmodule

### hdl/voice_activity_rate_tracker_unit.sv
// Voice activity rate tracker: one frame word in, one result word out. An
// analyze word runs the single shared restoring divider twice (16 steps for
// pause ratio, NW steps for speech rate, where NW = log2(ONSET_DEPTH) + 26 is
// the width of the speech rate division, 31 at the default depth of 32) and
// an eviction loop, which reads the oldest onset from the ring memory's one
// registered read port per check; a clear word skips both. One word is in
// work at a time; a finished result waits in the output register while the
// next word is accepted. The onset ring needs no clearing pass after reset.
`timescale 1ns / 1ps
module voice_activity_rate_tracker_unit #(
    parameter int ONSET_DEPTH = var_pkg::ONSET_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [var_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [var_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_command,
    input  logic [var_pkg::LEN_W-1:0]      i_frame_length,
    input  logic [var_pkg::RMS_W-1:0]      i_rms_level,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_voiced,
    output logic [var_pkg::Q_W-1:0]        o_pause_q16,
    output logic [var_pkg::Q_W-1:0]        o_rate_q8
);

    var_pkg::t_cmd cmd;
    var_pkg::t_sts sts;

    // sequencer
    var_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath
    var_datapath #(
        .DEPTH (ONSET_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_frame_length (i_frame_length),
        .i_rms_level    (i_rms_level),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_voiced       (o_voiced),
        .o_pause_q16    (o_pause_q16),
        .o_rate_q8      (o_rate_q8)
    );

endmodule

### hdl/var_checker.sv
// port level checks of the voice activity rate tracker
`timescale 1ns / 1ps
`include "assert_macros.svh"
module var_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [var_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [var_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           i_command,
    input logic [var_pkg::LEN_W-1:0]      i_frame_length,
    input logic [var_pkg::RMS_W-1:0]      i_rms_level,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_voiced,
    input logic [var_pkg::Q_W-1:0]        o_pause_q16,
    input logic [var_pkg::Q_W-1:0]        o_rate_q8
);

    // the block is not ready in the cycle after it accepts a word
    `VAR_ASSERT(a_busy_after_accept, (i_in_valid && o_in_ready) |=> !o_in_ready, "ready after accept")

    // reset leaves no result pending
    `VAR_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // a stalled result stays offered
    `VAR_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> o_out_valid, "result dropped")

    // a stalled result keeps its speech rate
    `VAR_ASSERT(a_rate_hold, (o_out_valid && !i_out_ready) |=> $stable(o_rate_q8), "rate moved")

endmodule

bind voice_activity_rate_tracker_unit var_checker u_var_checker (.*);

### tb/tb_voice_activity_rate_tracker_unit.sv
// testbench of the voice activity rate tracker: random frame words checked against a predictor
`timescale 1ns / 1ps
module tb_voice_activity_rate_tracker_unit;

    localparam int DEPTH    = var_pkg::ONSET_DEPTH_DEF;
    localparam int BUF_SIZE = 1024;
    localparam int CNT_W    = var_pkg::CNT_W;
    localparam int Q_W      = var_pkg::Q_W;

    typedef struct packed {
        logic                      cmd;
        logic [var_pkg::LEN_W-1:0] len;
        logic [var_pkg::RMS_W-1:0] rms;
    } t_frame;

    typedef struct packed {
        logic           voiced;
        logic [Q_W-1:0] pause;
        logic [Q_W-1:0] rate;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [var_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [var_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic i_command;
    logic [var_pkg::LEN_W-1:0] i_frame_length;
    logic [var_pkg::RMS_W-1:0] i_rms_level;
    logic o_out_valid;
    logic i_out_ready;
    logic o_voiced;
    logic [Q_W-1:0] o_pause_q16;
    logic [Q_W-1:0] o_rate_q8;

    voice_activity_rate_tracker_unit u_dut (.*);

    // predictor state and configuration
    logic [var_pkg::SR_W-1:0]  m_rate_hz;
    logic [var_pkg::THR_W-1:0] m_thresh;
    logic [var_pkg::WIN_W-1:0] m_window;
    logic [CNT_W-1:0] m_total;
    logic [CNT_W-1:0] m_voiced;
    logic             m_prev;
    logic [CNT_W-1:0] m_onsets [DEPTH];
    int               m_head;
    int               m_count;

    // pending frame words and expected result words
    t_frame  frame_buf [BUF_SIZE];
    t_result exp_buf [BUF_SIZE];
    int      frame_wr = 0;
    int      frame_rd = 0;
    int      exp_wr = 0;
    int      exp_rd = 0;
    int      errors = 0;
    int      frames_sent = 0;
    int      results_seen = 0;
    int      voiced_seen = 0;
    int      rate_seen = 0;
    bit      drive_gaps = 1;
    bit      sink_gaps = 1;
    bit      sink_hold = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [CNT_W-1:0] add_sat(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? var_pkg::CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic void clear_tracker();
        m_total = '0;
        m_voiced = '0;
        m_prev = 0;
        m_head = 0;
        m_count = 0;
    endfunction

    // work out the result of one frame word and advance the state
    function automatic t_result track_frame(t_frame f);
        t_result r;
        logic [CNT_W-1:0] unv, first, last;
        logic [79:0] num;
        logic [79:0] q;
        logic [CNT_W:0] lim;
        r = '0;
        if (f.cmd == var_pkg::CMD_CLEAR) begin
            clear_tracker();
            return r;
        end
        r.voiced = f.rms > m_thresh;
        m_total = add_sat(m_total, CNT_W'(f.len));
        if (r.voiced) m_voiced = add_sat(m_voiced, CNT_W'(f.len));
        if (r.voiced && !m_prev) begin
            if (m_count >= DEPTH) begin
                m_head = (m_head + 1) % DEPTH;
                m_count = DEPTH - 1;
            end
            m_onsets[(m_head + m_count) % DEPTH] = m_total;
            m_count++;
        end
        m_prev = r.voiced;
        // evict onsets that fell out of the window
        while (m_count > 0) begin
            lim = {1'b0, m_onsets[m_head]} + (CNT_W+1)'(m_window);
            if (lim < {1'b0, m_total}) begin
                m_head = (m_head + 1) % DEPTH;
                m_count--;
            end else break;
        end
        if (m_total != 0) begin
            unv = m_total - m_voiced;
            if (unv >= m_total) r.pause = var_pkg::Q_MAX;
            else begin
                q = {unv, 16'd0} / m_total;
                r.pause = (q > 80'(var_pkg::Q_MAX)) ? var_pkg::Q_MAX : q[Q_W-1:0];
            end
        end
        if (m_count >= 2) begin
            first = m_onsets[m_head];
            last = m_onsets[(m_head + m_count - 1) % DEPTH];
            if (last > first) begin
                num = 80'(m_count - 1) * 80'(m_rate_hz) * 80'd256;
                q = num / 80'(last - first);
                r.rate = (q > 80'(var_pkg::Q_MAX)) ? var_pkg::Q_MAX : q[Q_W-1:0];
            end
        end
        return r;
    endfunction

    // driver: offers the oldest pending word, predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            i_command <= 0;
            i_frame_length <= '0;
            i_rms_level <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                exp_buf[exp_wr % BUF_SIZE] = track_frame(frame_buf[frame_rd % BUF_SIZE]);
                exp_wr++;
                frame_rd++;
                frames_sent++;
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (frame_wr != frame_rd && !(drive_gaps && $urandom_range(99) < 33)) begin
                    i_in_valid <= 1;
                    i_command <= frame_buf[frame_rd % BUF_SIZE].cmd;
                    i_frame_length <= frame_buf[frame_rd % BUF_SIZE].len;
                    i_rms_level <= frame_buf[frame_rd % BUF_SIZE].rms;
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    // monitor: compares each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (exp_wr == exp_rd) begin
                    $display("%0t: unexpected result word v=%0d p=%0d r=%0d", $time,
                             o_voiced, o_pause_q16, o_rate_q8);
                    errors++;
                end else begin
                    e = exp_buf[exp_rd % BUF_SIZE];
                    exp_rd++;
                    voiced_seen += e.voiced;
                    rate_seen += (e.rate != 0);
                    if (e.voiced !== o_voiced) begin
                        $display("%0t: voiced flag expected %0d got %0d", $time, e.voiced,
                                 o_voiced);
                        errors++;
                    end
                    if (e.pause !== o_pause_q16) begin
                        $display("%0t: pause expected %0d got %0d", $time, e.pause,
                                 o_pause_q16);
                        errors++;
                    end
                    if (e.rate !== o_rate_q8) begin
                        $display("%0t: rate expected %0d got %0d", $time, e.rate,
                                 o_rate_q8);
                        errors++;
                    end
                end
            end
            i_out_ready <= !sink_hold && !(sink_gaps && $urandom_range(99) < 33);
        end
    end

    task automatic add_frame(logic cmd, int len, int rms);
        t_frame f;
        f.cmd = cmd;
        f.len = len[var_pkg::LEN_W-1:0];
        f.rms = rms[var_pkg::RMS_W-1:0];
        frame_buf[frame_wr % BUF_SIZE] = f;
        frame_wr++;
    endtask

    task automatic wait_drained();
        while (frame_wr != frame_rd || i_in_valid || exp_wr != exp_rd) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(var_pkg::t_cfg_idx idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[var_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            var_pkg::CFG_SAMPLE_RATE:     m_rate_hz = val[var_pkg::SR_W-1:0];
            var_pkg::CFG_VOICE_THRESHOLD: m_thresh = val[var_pkg::THR_W-1:0];
            default:                      m_window = val[var_pkg::WIN_W-1:0];
        endcase
    endtask

    // random speech-like frames: a random mix of voiced, silent, arbitrary and clear words
    task automatic add_bursts(int n, int max_len);
        int k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0: add_frame(var_pkg::CMD_CLEAR, $urandom, $urandom);
                1, 2: add_frame(var_pkg::CMD_ANALYZE, $urandom, $urandom);
                3, 4, 5: add_frame(var_pkg::CMD_ANALYZE, $urandom_range(max_len),
                                   m_thresh + $urandom_range(1, 2000));
                default: add_frame(var_pkg::CMD_ANALYZE, $urandom_range(max_len),
                                   $urandom_range(m_thresh));
            endcase
        end
    endtask

    // stimulus
    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        m_rate_hz = var_pkg::SR_RST;
        m_thresh = var_pkg::THR_RST;
        m_window = var_pkg::WIN_RST;
        clear_tracker();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, threshold edge, zero length, clear
        add_frame(var_pkg::CMD_ANALYZE, 0, 0);
        add_frame(var_pkg::CMD_ANALYZE, 0, 1025);
        add_frame(var_pkg::CMD_ANALYZE, 480, 1024);
        add_frame(var_pkg::CMD_ANALYZE, 480, 1025);
        add_frame(var_pkg::CMD_ANALYZE, 65535, 0);
        add_frame(var_pkg::CMD_ANALYZE, 65535, 65535);
        add_frame(var_pkg::CMD_ANALYZE, 100, 0);
        add_frame(var_pkg::CMD_ANALYZE, 100, 65535);
        add_frame(var_pkg::CMD_ANALYZE, 300, 10);
        add_frame(var_pkg::CMD_ANALYZE, 300, 5000);
        add_frame(var_pkg::CMD_CLEAR, 65535, 65535);
        add_frame(var_pkg::CMD_ANALYZE, 1, 2000);
        add_frame(var_pkg::CMD_ANALYZE, 1, 0);
        add_frame(var_pkg::CMD_ANALYZE, 1, 2000);
        add_frame(var_pkg::CMD_CLEAR, 0, 0);
        wait_drained();

        // ring overflow and huge rate with the widest window
        write_reg(var_pkg::CFG_SAMPLE_RATE, 192000);
        write_reg(var_pkg::CFG_VOICE_THRESHOLD, 0);
        write_reg(var_pkg::CFG_HISTORY_WINDOW, 1048575);
        for (int k = 0; k < 40; k++) begin
            add_frame(var_pkg::CMD_ANALYZE, $urandom_range(1, 50), $urandom_range(1, 65535));
            add_frame(var_pkg::CMD_ANALYZE, $urandom_range(0, 50), 0);
        end
        wait_drained();

        // eviction with minimum window, low rate, top threshold
        write_reg(var_pkg::CFG_HISTORY_WINDOW, 1);
        write_reg(var_pkg::CFG_SAMPLE_RATE, 8000);
        add_bursts(60, 20);
        wait_drained();
        write_reg(var_pkg::CFG_VOICE_THRESHOLD, 65535);
        add_bursts(10, 100);
        wait_drained();
        write_reg(var_pkg::CFG_VOICE_THRESHOLD, 1024);
        write_reg(var_pkg::CFG_HISTORY_WINDOW, 5000);
        write_reg(var_pkg::CFG_SAMPLE_RATE, 48000);
        // back pressure: output held off while input keeps offering
        sink_hold = 1;
        add_bursts(40, 600);
        repeat (1500) @(posedge i_clk);
        sink_hold = 0;
        wait_drained();

        // no idling stretch, then random mix
        drive_gaps = 0;
        sink_gaps = 0;
        write_reg(var_pkg::CFG_SAMPLE_RATE, $urandom_range(8000, 192000));
        write_reg(var_pkg::CFG_VOICE_THRESHOLD, $urandom_range(0, 4000));
        add_bursts(60, 2000);
        wait_drained();
        drive_gaps = 1;
        sink_gaps = 1;
        write_reg(var_pkg::CFG_HISTORY_WINDOW, $urandom_range(1000, 1048575));
        add_bursts(170, 1000);
        wait_drained();

        $display("covered %0d frame words, %0d results (%0d voiced, %0d nonzero rates)",
                 frames_sent, results_seen, voiced_seen, rate_seen);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
